[hdl/prd_pkg.sv]
// Shared constants and types for the plateau rate detector.
package prd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SECONDS  = 2'd0,
		CFG_ENTER_THRESHOLD = 2'd1,
		CFG_EXIT_THRESHOLD  = 2'd2
	} cfg_index_t;

	// Field widths
	localparam int unsigned WINDOW_W  = 16;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned MINUTES_W = 27;

	// Register reset values
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd600;
	localparam logic [WORD_W-1:0]   ENTER_RESET  = 32'd1;
	localparam logic [WORD_W-1:0]   EXIT_RESET   = 32'd10;

	// Divide by 60 as (x >> 2) / 15: multiply by ceil(2^35 / 15), keep bits from 35 up
	localparam logic [WORD_W-1:0] RECIP_15    = 32'h8888_8889;
	localparam int unsigned       RECIP_SHIFT = 35;
	localparam int unsigned       QUARTER_W   = WORD_W - 2;
	localparam int unsigned       PROD_W      = QUARTER_W + WORD_W;

	// One result beat
	typedef struct packed {
		logic                 window_closed;
		logic [WORD_W-1:0]    window_gain;
		logic                 plateau_flag;
		logic                 entered_pulse;
		logic                 exited_pulse;
		logic [MINUTES_W-1:0] plateau_minutes;
		logic [WORD_W-1:0]    entered_total;
		logic [WORD_W-1:0]    exited_total;
	} result_t;

endpackage

[hdl/plateau_rate_detector_hysteresis.sv]
// Plateau rate detector: windowed discovery gain with enter/exit hysteresis.
// Path: an accepted check beat is captured in the input register, then registered in the
// result reg once the result side is free, and its result beat is offered from there.
// Throughput: one check per cycle unless out_ready stalls; state update and result come from
// compares, subtracts and a 30x32 minutes reciprocal multiply between input and result regs.
// Reset: arst_n clears the pipeline valids, the tracking state and restores default config.
module plateau_rate_detector_hysteresis (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [prd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prd_pkg::WORD_W-1:0]    cfg_data,
	// check input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prd_pkg::WORD_W-1:0]    now_seconds,
	input  logic [prd_pkg::WORD_W-1:0]    edge_count,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          window_closed,
	output logic [prd_pkg::WORD_W-1:0]    window_gain,
	output logic                          plateau_flag,
	output logic                          entered_pulse,
	output logic                          exited_pulse,
	output logic [prd_pkg::MINUTES_W-1:0] plateau_minutes,
	output logic [prd_pkg::WORD_W-1:0]    entered_total,
	output logic [prd_pkg::WORD_W-1:0]    exited_total
);
	import prd_pkg::*;

	// configuration
	logic [WINDOW_W-1:0] window_q;
	logic [WORD_W-1:0]   enter_th_q;
	logic [WORD_W-1:0]   exit_th_q;

	// tracking state
	logic              armed_q;
	logic [WORD_W-1:0] win_start_q;
	logic [WORD_W-1:0] prev_count_q;
	logic [WORD_W-1:0] last_gain_q;
	logic              in_plateau_q;
	logic [WORD_W-1:0] entered_time_q;
	logic [WORD_W-1:0] entry_cnt_q;
	logic [WORD_W-1:0] exit_cnt_q;

	// input stage
	logic              valid_s1;
	logic [WORD_W-1:0] now_s1;
	logic [WORD_W-1:0] count_s1;

	// result stage
	logic    out_valid_q;
	result_t res_q;

	logic    advance;
	logic    accept;

	logic [WORD_W-1:0]    elapsed;
	logic [WORD_W-1:0]    gain;
	logic                 close;
	logic                 below_enter;
	logic                 do_enter;
	logic                 do_exit;
	logic [WORD_W-1:0]    plateau_secs;
	logic [PROD_W-1:0]    min_prod;
	logic [MINUTES_W-1:0] minutes;
	logic [WORD_W-1:0]    entry_cnt_d;
	logic [WORD_W-1:0]    exit_cnt_d;
	logic                 in_plateau_d;
	result_t              res_d;

	// handshake: result register parts the two sides
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RESET;
			enter_th_q <= ENTER_RESET;
			exit_th_q  <= EXIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_SECONDS:  window_q   <= cfg_data[WINDOW_W-1:0];
				CFG_ENTER_THRESHOLD: enter_th_q <= cfg_data;
				CFG_EXIT_THRESHOLD:  exit_th_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1   <= now_seconds;
			count_s1 <= edge_count;
		end
	end

	// window close and gain; negative elapsed and falling counts clamp to zero
	assign elapsed     = (now_s1 >= win_start_q) ? (now_s1 - win_start_q) : '0;
	assign close       = armed_q && (elapsed >= {{(WORD_W-WINDOW_W){1'b0}}, window_q});
	assign gain        = (count_s1 >= prev_count_q) ? (count_s1 - prev_count_q) : '0;
	assign below_enter = gain < enter_th_q;
	assign do_enter    = close && below_enter && !in_plateau_q;
	assign do_exit     = close && !below_enter && (gain >= exit_th_q) && in_plateau_q;

	// plateau length in minutes via reciprocal of 15 on seconds/4
	assign plateau_secs = (now_s1 > entered_time_q) ? (now_s1 - entered_time_q) : '0;
	assign min_prod     = PROD_W'(plateau_secs[WORD_W-1:2]) * PROD_W'(RECIP_15);
	assign minutes      = do_exit ? min_prod[RECIP_SHIFT +: MINUTES_W] : '0;

	assign entry_cnt_d  = do_enter ? entry_cnt_q + 1'b1 : entry_cnt_q;
	assign exit_cnt_d   = do_exit  ? exit_cnt_q + 1'b1  : exit_cnt_q;
	assign in_plateau_d = do_enter ? 1'b1 : (do_exit ? 1'b0 : in_plateau_q);

	// next result beat
	always_comb begin
		res_d.window_closed   = close;
		res_d.window_gain     = close ? gain : last_gain_q;
		res_d.plateau_flag    = in_plateau_d;
		res_d.entered_pulse   = do_enter;
		res_d.exited_pulse    = do_exit;
		res_d.plateau_minutes = minutes;
		res_d.entered_total   = entry_cnt_d;
		res_d.exited_total    = exit_cnt_d;
	end

	// tracking state update, one check per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			win_start_q    <= '0;
			prev_count_q   <= '0;
			last_gain_q    <= '0;
			in_plateau_q   <= 1'b0;
			entered_time_q <= '0;
			entry_cnt_q    <= '0;
			exit_cnt_q     <= '0;
		end else if (advance) begin
			if (!armed_q || close) begin
				win_start_q  <= now_s1;
				prev_count_q <= count_s1;
			end
			armed_q <= 1'b1;
			if (close) begin
				last_gain_q <= gain;
			end
			if (do_enter) begin
				entered_time_q <= now_s1;
			end else if (do_exit) begin
				entered_time_q <= '0;
			end
			in_plateau_q <= in_plateau_d;
			entry_cnt_q  <= entry_cnt_d;
			exit_cnt_q   <= exit_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign window_closed   = res_q.window_closed;
	assign window_gain     = res_q.window_gain;
	assign plateau_flag    = res_q.plateau_flag;
	assign entered_pulse   = res_q.entered_pulse;
	assign exited_pulse    = res_q.exited_pulse;
	assign plateau_minutes = res_q.plateau_minutes;
	assign entered_total   = res_q.entered_total;
	assign exited_total    = res_q.exited_total;

	// checks
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.entered_pulse && res_q.exited_pulse))
		else $error("entry and exit in one beat");

	a_pulse_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.entered_pulse || res_q.exited_pulse) |-> res_q.window_closed)
		else $error("plateau change without a closed window");

	a_flag_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!res_q.entered_pulse || res_q.plateau_flag)
			&& (!res_q.exited_pulse || !res_q.plateau_flag))
		else $error("plateau flag disagrees with pulse");

	a_minutes_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.plateau_minutes != '0) |-> res_q.exited_pulse)
		else $error("plateau minutes outside exit");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without output backpressure");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !armed_q |=> !res_q.window_closed && out_valid_q)
		else $error("arming check closed a window");

endmodule
